/* hdl/cell_list_neighbor_search_assert.svh */
// Assertion macros for the neighbor search checker.
`ifndef CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH
`define CELL_LIST_NEIGHBOR_SEARCH_ASSERT_SVH

// Check outside reset.
`define CLNS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check at every edge, reset included.
`define CLNS_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

/* hdl/clns_pkg.sv */
package clns_pkg;

  localparam int MaxAtoms   = 1024;
  localparam int AtomW      = $clog2(MaxAtoms);
  localparam int CntW       = AtomW + 1;
  localparam int MaxCells   = 4096;
  localparam int CellW      = $clog2(MaxCells);
  localparam int MaxResults = 64;
  localparam int ResW       = $clog2(MaxResults + 1);
  localparam int SiteW      = 10;
  localparam int SiteCntW   = 11;
  localparam int CfgIdxW    = 2;
  localparam int CfgDataW   = 31;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_BOX    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RADIUS = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_DIM    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_CELL   = 2'd3;

  localparam logic [30:0] BoxReset    = 31'd655360;
  localparam logic [29:0] RadiusReset = 30'd65536;
  localparam logic [4:0]  DimReset    = 5'd5;
  localparam logic [30:0] CellReset   = 31'd131072;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
  } in_req_t;

  typedef struct packed {
    logic [9:0] atom_index;
    logic [9:0] site_number;
    logic       found;
    logic       last;
    logic       overflow;
  } out_res_t;

  typedef struct packed {
    logic [30:0] box_length;
    logic [29:0] site_radius;
    logic [4:0]  dim;
    logic [30:0] cell_length;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_QUERY
  } op_e;

  typedef struct packed {
    op_e                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [3:0]         cx;
    logic [3:0]         cy;
    logic [3:0]         cz;
    logic [CellW-1:0]   cell_id;
  } cmd_t;

  function automatic logic signed [31:0] wrap_coord(logic signed [31:0] c, logic [30:0] len);
    logic signed [32:0] cw;
    logic signed [32:0] lw;
    logic signed [32:0] r;
    cw = 33'(c);
    lw = {2'b00, len};
    if (cw >= lw) begin
      r = cw - lw;
    end else if (cw <= -33'sd2) begin
      r = cw + lw;
    end else begin
      r = cw;
    end
    return r[31:0];
  endfunction

  function automatic logic [CellW-1:0] cell_index(logic [3:0] cx, logic [3:0] cy,
                                                  logic [3:0] cz, logic [4:0] dim);
    logic [8:0]  row;
    logic [12:0] idx;
    row = 9'(cx) * 9'(dim) + 9'(cy);
    idx = 13'(row) * 13'(dim) + 13'(cz);
    return idx[CellW-1:0];
  endfunction

endpackage

/* hdl/clns_front.sv */
module clns_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clns_pkg::cfg_t     cfg_i,
  input  logic               push_i,
  input  logic               hold_i,
  input  clns_pkg::in_req_t  req_i,
  output logic               busy_o,
  output logic               q_push_o,
  output clns_pkg::cmd_t     q_cmd_o,
  input  logic               q_full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_CELL,
    F_PUSH
  } state_e;

  state_e             state_q;
  clns_pkg::op_e      op_q;
  logic signed [31:0] pos_q [3];
  logic [3:0]         k_q   [3];
  logic [35:0]        acc_q [3];
  logic               neg_q [3];

  logic signed [31:0] wrapped [3];
  logic [2:0]         inc;
  logic [3:0]         dim_m1;
  logic               accept;

  assign accept = push_i && !hold_i && (state_q == F_IDLE);
  assign dim_m1 = 4'(cfg_i.dim - 5'd1);

  assign wrapped[0] = clns_pkg::wrap_coord(req_i.coord_x, cfg_i.box_length);
  assign wrapped[1] = clns_pkg::wrap_coord(req_i.coord_y, cfg_i.box_length);
  assign wrapped[2] = clns_pkg::wrap_coord(req_i.coord_z, cfg_i.box_length);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inc[i] = !neg_q[i] && (k_q[i] < dim_m1) && (acc_q[i] <= {4'b0000, pos_q[i][31:0]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      op_q    <= clns_pkg::OP_CLEAR;
      for (int i = 0; i < 3; i++) begin
        pos_q[i] <= '0;
        k_q[i]   <= '0;
        acc_q[i] <= '0;
        neg_q[i] <= 1'b0;
      end
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            for (int i = 0; i < 3; i++) begin
              pos_q[i] <= wrapped[i];
              k_q[i]   <= '0;
              acc_q[i] <= 36'(cfg_i.cell_length);
              neg_q[i] <= wrapped[i][31];
            end
            unique case (req_i.mode)
              clns_pkg::MODE_CLEAR: begin
                op_q    <= clns_pkg::OP_CLEAR;
                state_q <= F_PUSH;
              end
              clns_pkg::MODE_LOAD: begin
                op_q    <= clns_pkg::OP_LOAD;
                state_q <= F_CELL;
              end
              clns_pkg::MODE_QUERY: begin
                op_q    <= clns_pkg::OP_QUERY;
                state_q <= F_CELL;
              end
              default: begin
                state_q <= F_IDLE;
              end
            endcase
          end
        end
        F_CELL: begin
          if (|inc) begin
            for (int i = 0; i < 3; i++) begin
              if (inc[i]) begin
                k_q[i]   <= k_q[i] + 4'd1;
                acc_q[i] <= acc_q[i] + 36'(cfg_i.cell_length);
              end
            end
          end else begin
            state_q <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

  assign busy_o   = (state_q != F_IDLE);
  assign q_push_o = (state_q == F_PUSH);

  always_comb begin
    q_cmd_o.op      = op_q;
    q_cmd_o.x       = pos_q[0];
    q_cmd_o.y       = pos_q[1];
    q_cmd_o.z       = pos_q[2];
    q_cmd_o.cx      = k_q[0];
    q_cmd_o.cy      = k_q[1];
    q_cmd_o.cz      = k_q[2];
    q_cmd_o.cell_id = clns_pkg::cell_index(k_q[0], k_q[1], k_q[2], cfg_i.dim);
  end

endmodule

/* hdl/clns_cmd_queue.sv */
module clns_cmd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  clns_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output clns_pkg::cmd_t cmd_o,
  output logic           empty_o
);

  clns_pkg::cmd_t mem_q [2];
  logic           wr_q;
  logic           rd_q;
  logic [1:0]     cnt_q;
  logic           do_push;
  logic           do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= !wr_q;
      end
      if (do_pop) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

/* hdl/clns_back.sv */
module clns_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  clns_pkg::cfg_t     cfg_i,
  input  logic               q_empty_i,
  input  clns_pkg::cmd_t     q_cmd_i,
  output logic               q_pop_o,
  output logic               clearing_o,
  input  logic               pop_i,
  output logic               empty_o,
  output clns_pkg::out_res_t res_o
);

  localparam int AtomW = clns_pkg::AtomW;
  localparam int CntW  = clns_pkg::CntW;
  localparam int CellW = clns_pkg::CellW;

  typedef enum logic [3:0] {
    B_CLR,
    B_IDLE,
    B_LD,
    B_CELL,
    B_HEAD,
    B_BRU,
    B_FETCH,
    B_DIFF,
    B_MUL,
    B_CMP,
    B_ADV,
    B_NBR,
    B_END
  } state_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } pos_t;

  state_e                     state_q;
  clns_pkg::cmd_t             cmd_q;
  logic [CellW-1:0]           clr_q;
  logic [CntW-1:0]            cnt_q;
  logic [clns_pkg::SiteCntW-1:0] site_cnt_q;
  logic [clns_pkg::SiteW-1:0] site_q;
  logic [CntW-1:0]            a_q;
  logic [AtomW:0]             link_q;
  logic [1:0]                 ox_q;
  logic [1:0]                 oy_q;
  logic [1:0]                 oz_q;
  logic                       brute_q;
  logic [clns_pkg::ResW-1:0]  n_q;
  logic                       ovf_q;
  logic                       pend_v_q;
  logic [AtomW-1:0]           pend_q;
  logic [61:0]                cut_sq_q;
  logic [30:0]                m_q  [3];
  logic [61:0]                sq_q [3];
  logic                       far_q;

  logic [AtomW:0]   head_mem [clns_pkg::MaxCells];
  logic [AtomW:0]   head_rd_q;
  logic [CellW-1:0] head_ra;
  logic [CellW-1:0] head_wa;
  logic [AtomW:0]   head_wd;
  logic             head_we;

  pos_t           pos_mem  [clns_pkg::MaxAtoms];
  logic [AtomW:0] next_mem [clns_pkg::MaxAtoms];
  pos_t           pos_rd_q;
  logic [AtomW:0] next_rd_q;
  logic           atom_we;

  clns_pkg::out_res_t of_mem_q [2];
  logic               of_wr_q;
  logic               of_rd_q;
  logic [1:0]         of_cnt_q;
  logic               of_space;
  logic               of_push;
  logic               of_pop;
  clns_pkg::out_res_t of_data;

  logic [30:0]      cut;
  logic [CellW-1:0] nbr_cell;
  logic [33:0]      mag [3];
  logic [2:0]       far;
  logic [63:0]      rsq;
  logic             hit;

  function automatic logic [3:0] nbr_axis(logic [3:0] c, logic [1:0] o, logic [4:0] dim);
    logic [5:0] t;
    logic [5:0] d2;
    t  = 6'(c) + 6'(o) + 6'(dim) - 6'd1;
    d2 = {dim, 1'b0};
    if (t >= d2) begin
      t = t - d2;
    end else if (t >= 6'(dim)) begin
      t = t - 6'(dim);
    end
    return t[3:0];
  endfunction

  function automatic logic [33:0] abs_image(logic signed [31:0] s, logic signed [31:0] a,
                                            logic [30:0] len);
    logic signed [33:0] dx;
    logic signed [33:0] two;
    logic signed [33:0] lw;
    logic signed [33:0] r;
    dx  = 34'(s) - 34'(a);
    two = dx <<< 1;
    lw  = {3'b000, len};
    if (two > lw) begin
      r = dx - lw;
    end else if (two < -lw) begin
      r = dx + lw;
    end else begin
      r = dx;
    end
    if (r < 0) begin
      r = -r;
    end
    return r;
  endfunction

  assign cut      = {cfg_i.site_radius, 1'b0};
  assign nbr_cell = clns_pkg::cell_index(nbr_axis(cmd_q.cx, ox_q, cfg_i.dim),
                                         nbr_axis(cmd_q.cy, oy_q, cfg_i.dim),
                                         nbr_axis(cmd_q.cz, oz_q, cfg_i.dim), cfg_i.dim);

  assign mag[0] = abs_image(cmd_q.x, pos_rd_q.x, cfg_i.box_length);
  assign mag[1] = abs_image(cmd_q.y, pos_rd_q.y, cfg_i.box_length);
  assign mag[2] = abs_image(cmd_q.z, pos_rd_q.z, cfg_i.box_length);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      far[k] = (mag[k] >= {3'b000, cut});
    end
  end

  assign rsq = 64'(sq_q[0]) + 64'(sq_q[1]) + 64'(sq_q[2]);
  assign hit = !far_q && (rsq < 64'(cut_sq_q)) && (a_q < cnt_q);

  assign q_pop_o    = (state_q == B_IDLE) && !q_empty_i;
  assign clearing_o = (state_q == B_CLR);

  assign head_ra = (state_q == B_IDLE) ? q_cmd_i.cell_id : nbr_cell;
  assign head_we = (state_q == B_CLR) || (state_q == B_LD);
  assign head_wa = (state_q == B_CLR) ? clr_q : cmd_q.cell_id;
  assign head_wd = (state_q == B_CLR) ? '0 : {1'b1, cnt_q[AtomW-1:0]};
  assign atom_we = (state_q == B_LD);

  always_ff @(posedge clk_i) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    head_rd_q <= head_mem[head_ra];
  end

  always_ff @(posedge clk_i) begin
    if (atom_we) begin
      pos_mem[cnt_q[AtomW-1:0]]  <= '{x: cmd_q.x, y: cmd_q.y, z: cmd_q.z};
      next_mem[cnt_q[AtomW-1:0]] <= head_rd_q;
    end
    pos_rd_q  <= pos_mem[a_q[AtomW-1:0]];
    next_rd_q <= next_mem[a_q[AtomW-1:0]];
  end

  assign of_space = (of_cnt_q != 2'd2);
  assign empty_o  = (of_cnt_q == 2'd0);
  assign of_pop   = pop_i && !empty_o;
  assign res_o    = of_mem_q[of_rd_q];
  assign of_push  = ((state_q == B_CMP) && hit && (n_q != clns_pkg::ResW'(clns_pkg::MaxResults))
                     && pend_v_q && of_space) || ((state_q == B_END) && of_space);

  always_comb begin
    of_data.site_number = site_q;
    if (state_q == B_END) begin
      of_data.atom_index = pend_v_q ? pend_q : '0;
      of_data.found      = pend_v_q;
      of_data.last       = 1'b1;
      of_data.overflow   = pend_v_q && ovf_q;
    end else begin
      of_data.atom_index = pend_q;
      of_data.found      = 1'b1;
      of_data.last       = 1'b0;
      of_data.overflow   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      of_wr_q  <= 1'b0;
      of_rd_q  <= 1'b0;
      of_cnt_q <= 2'd0;
    end else begin
      if (of_push) begin
        of_wr_q <= !of_wr_q;
      end
      if (of_pop) begin
        of_rd_q <= !of_rd_q;
      end
      of_cnt_q <= of_cnt_q + 2'(of_push) - 2'(of_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (of_push) begin
      of_mem_q[of_wr_q] <= of_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_CLR;
      cmd_q      <= '0;
      clr_q      <= '0;
      cnt_q      <= '0;
      site_cnt_q <= '0;
      site_q     <= '0;
      a_q        <= '0;
      link_q     <= '0;
      ox_q       <= '0;
      oy_q       <= '0;
      oz_q       <= '0;
      brute_q    <= 1'b0;
      n_q        <= '0;
      ovf_q      <= 1'b0;
      pend_v_q   <= 1'b0;
      pend_q     <= '0;
      cut_sq_q   <= '0;
      far_q      <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        m_q[k]  <= '0;
        sq_q[k] <= '0;
      end
    end else begin
      unique case (state_q)
        B_CLR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == CellW'(clns_pkg::MaxCells - 1)) begin
            state_q <= B_IDLE;
          end
        end
        B_IDLE: begin
          if (!q_empty_i) begin
            cmd_q <= q_cmd_i;
            unique case (q_cmd_i.op)
              clns_pkg::OP_CLEAR: begin
                cnt_q      <= '0;
                site_cnt_q <= '0;
                clr_q      <= '0;
                state_q    <= B_CLR;
              end
              clns_pkg::OP_LOAD: begin
                if (cnt_q != CntW'(clns_pkg::MaxAtoms)) begin
                  state_q <= B_LD;
                end
              end
              clns_pkg::OP_QUERY: begin
                site_q     <= site_cnt_q[clns_pkg::SiteW-1:0];
                site_cnt_q <= site_cnt_q + 1'b1;
                n_q        <= '0;
                ovf_q      <= 1'b0;
                pend_v_q   <= 1'b0;
                cut_sq_q   <= 62'(cut) * 62'(cut);
                ox_q       <= '0;
                oy_q       <= '0;
                oz_q       <= '0;
                a_q        <= '0;
                brute_q    <= (cfg_i.dim < 5'd3);
                state_q    <= (cfg_i.dim < 5'd3) ? B_BRU : B_CELL;
              end
              default: begin
                state_q <= B_IDLE;
              end
            endcase
          end
        end
        B_LD: begin
          cnt_q   <= cnt_q + 1'b1;
          state_q <= B_IDLE;
        end
        B_CELL: begin
          state_q <= B_HEAD;
        end
        B_HEAD: begin
          if (head_rd_q[AtomW]) begin
            a_q     <= {1'b0, head_rd_q[AtomW-1:0]};
            state_q <= B_FETCH;
          end else begin
            state_q <= B_NBR;
          end
        end
        B_BRU: begin
          state_q <= (a_q < cnt_q) ? B_FETCH : B_END;
        end
        B_FETCH: begin
          state_q <= B_DIFF;
        end
        B_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            m_q[k] <= mag[k][30:0];
          end
          far_q   <= |far;
          link_q  <= next_rd_q;
          state_q <= B_MUL;
        end
        B_MUL: begin
          for (int k = 0; k < 3; k++) begin
            sq_q[k] <= 62'(m_q[k]) * 62'(m_q[k]);
          end
          state_q <= B_CMP;
        end
        B_CMP: begin
          priority if (!hit) begin
            state_q <= B_ADV;
          end else if (n_q == clns_pkg::ResW'(clns_pkg::MaxResults)) begin
            ovf_q   <= 1'b1;
            state_q <= B_END;
          end else if (!pend_v_q || of_space) begin
            pend_q   <= a_q[AtomW-1:0];
            pend_v_q <= 1'b1;
            n_q      <= n_q + 1'b1;
            state_q  <= B_ADV;
          end
        end
        B_ADV: begin
          priority if (brute_q) begin
            a_q     <= a_q + 1'b1;
            state_q <= B_BRU;
          end else if (link_q[AtomW]) begin
            a_q     <= {1'b0, link_q[AtomW-1:0]};
            state_q <= B_FETCH;
          end else begin
            state_q <= B_NBR;
          end
        end
        B_NBR: begin
          priority if (oz_q != 2'd2) begin
            oz_q    <= oz_q + 2'd1;
            state_q <= B_CELL;
          end else if (oy_q != 2'd2) begin
            oz_q    <= '0;
            oy_q    <= oy_q + 2'd1;
            state_q <= B_CELL;
          end else if (ox_q != 2'd2) begin
            oz_q    <= '0;
            oy_q    <= '0;
            ox_q    <= ox_q + 2'd1;
            state_q <= B_CELL;
          end else begin
            state_q <= B_END;
          end
        end
        B_END: begin
          if (of_space) begin
            state_q <= B_IDLE;
          end
        end
        default: begin
          state_q <= B_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/cell_list_neighbor_search.sv */
// Periodic cell-list neighbor search. Requests load atoms, query sites or clear everything;
// each query returns one result per neighbor atom (at most 64, the final one flagged last and
// carrying overflow), or a single not-found result. After reset and after every clear request
// the 4096 cell heads are swept, one per cycle, and full stays high during the sweep.
// The front side wraps coordinates and bins them by stepping the cell index along all three
// axes at once; the back side writes one cell head and link per load and, per query, walks
// the atom list of each neighbor cell, or scans every loaded atom when there are fewer than 3
// cells per edge. A 2-entry command queue and a 2-entry result queue sit between the two
// sides and the ports.
module cell_list_neighbor_search (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               push,
  output logic                               full,
  input  clns_pkg::in_req_t                  in_req_i,
  output logic                               empty,
  input  logic                               pop,
  output clns_pkg::out_res_t                 out_res_o,
  input  logic                               cfg_we_i,
  input  logic [clns_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [clns_pkg::CfgDataW-1:0]      cfg_data_i
);

  logic [30:0]    box_q;
  logic [29:0]    radius_q;
  logic [4:0]     dim_q;
  logic [30:0]    cell_q;
  clns_pkg::cfg_t cfg;

  logic           front_busy;
  logic           clearing;
  logic           fq_push;
  clns_pkg::cmd_t fq_cmd;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;
  clns_pkg::cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_q    <= clns_pkg::BoxReset;
      radius_q <= clns_pkg::RadiusReset;
      dim_q    <= clns_pkg::DimReset;
      cell_q   <= clns_pkg::CellReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        clns_pkg::REG_BOX:    box_q    <= cfg_data_i[30:0];
        clns_pkg::REG_RADIUS: radius_q <= cfg_data_i[29:0];
        clns_pkg::REG_DIM:    dim_q    <= cfg_data_i[4:0];
        clns_pkg::REG_CELL:   cell_q   <= cfg_data_i[30:0];
      endcase
    end
  end

  always_comb begin
    cfg.box_length  = box_q;
    cfg.site_radius = radius_q;
    priority if (dim_q == 5'd0) begin
      cfg.dim = 5'd1;
    end else if (dim_q > 5'd16) begin
      cfg.dim = 5'd16;
    end else begin
      cfg.dim = dim_q;
    end
    cfg.cell_length = (cell_q == '0) ? 31'd1 : cell_q;
  end

  assign full = front_busy || clearing;

  clns_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .push_i   (push),
    .hold_i   (clearing),
    .req_i    (in_req_i),
    .busy_o   (front_busy),
    .q_push_o (fq_push),
    .q_cmd_o  (fq_cmd),
    .q_full_i (q_full)
  );

  clns_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .cmd_i   (fq_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  clns_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .clearing_o (clearing),
    .pop_i      (pop),
    .empty_o    (empty),
    .res_o      (out_res_o)
  );

endmodule

/* hdl/clns_checker.sv */
`include "cell_list_neighbor_search_assert.svh"

module clns_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input clns_pkg::out_res_t out_res_o
);

  `CLNS_ASSERT(a_mid_found, !empty && !out_res_o.last |-> out_res_o.found, "non-final result without a hit")
  `CLNS_ASSERT(a_miss_clean, !empty && !out_res_o.found |-> out_res_o.last && !out_res_o.overflow && out_res_o.atom_index == 10'd0, "malformed not-found result")
  `CLNS_ASSERT(a_hold, !empty && !pop |=> !empty && $stable(out_res_o), "waiting result changed")
  `CLNS_ASSERT(a_same_site, !empty && pop && !out_res_o.last |=> empty || out_res_o.site_number == $past(out_res_o.site_number), "site number changed inside a query")
  `CLNS_ASSERT_RST(a_rst_empty, !rst_ni |-> empty, "result shown during reset")

endmodule

bind cell_list_neighbor_search clns_checker u_clns_checker (.*);

/* tb/tb_cell_list_neighbor_search.sv */
module tb_cell_list_neighbor_search;

  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 5000;
  localparam int AtomCap = 1024;
  localparam int CellCap = 4096;
  localparam int HitCap = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic push = 1'b0;
  logic full;
  clns_pkg::in_req_t in_req_i = '0;
  logic empty;
  logic pop = 1'b0;
  clns_pkg::out_res_t out_res_o;
  logic cfg_we_i = 1'b0;
  logic [clns_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [clns_pkg::CfgDataW-1:0] cfg_data_i = '0;

  cell_list_neighbor_search uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_req_i(in_req_i),
    .empty(empty),
    .pop(pop),
    .out_res_o(out_res_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // search state mirror
  int unsigned box_len = 655360;
  int unsigned radius = 65536;
  int unsigned dim_reg = 5;
  int unsigned cell_len = 131072;
  longint pos_x[AtomCap];
  longint pos_y[AtomCap];
  longint pos_z[AtomCap];
  int unsigned link_atom[AtomCap];
  bit link_ok[AtomCap];
  int unsigned head_atom[CellCap];
  bit head_ok[CellCap];
  int unsigned n_atoms = 0;
  int unsigned n_sites = 0;

  clns_pkg::in_req_t pending_reqs[$];
  clns_pkg::out_res_t expected_hits[$];
  int snd_idle = 0;
  int rcv_idle = 0;
  logic hold_req = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint wrap_pos(logic signed [31:0] c);
    longint cc;
    cc = longint'(c);
    if (cc >= longint'(box_len)) return cc - longint'(box_len);
    if (cc <= -2) return cc + longint'(box_len);
    return cc;
  endfunction

  function automatic longint bin_of(longint c, longint d);
    longint q;
    q = c / ((cell_len == 0) ? 64'sd1 : longint'(cell_len));
    if (q < 0) q = 0;
    if (q > d - 1) q = d - 1;
    return q;
  endfunction

  function automatic longint fold(longint dx);
    if (2 * dx > longint'(box_len)) return dx - longint'(box_len);
    if (2 * dx < -longint'(box_len)) return dx + longint'(box_len);
    return dx;
  endfunction

  function automatic bit is_near(longint sx, longint sy, longint sz, int unsigned a);
    longint unsigned cut, m, rsq;
    longint dv[3];
    cut = 2 * longint'(radius);
    dv[0] = fold(sx - pos_x[a]);
    dv[1] = fold(sy - pos_y[a]);
    dv[2] = fold(sz - pos_z[a]);
    rsq = 0;
    for (int k = 0; k < 3; k++) begin
      m = (dv[k] < 0) ? -dv[k] : dv[k];
      if (m >= cut) return 1'b0;
      rsq += m * m;
    end
    return rsq < cut * cut;
  endfunction

  task automatic predict_search(input clns_pkg::in_req_t r);
    longint x, y, z, d, cx, cy, cz, cell_no;
    int unsigned a, site, steps;
    int hits[$];
    bit ovf, v;
    clns_pkg::out_res_t res;
    x = wrap_pos(r.coord_x);
    y = wrap_pos(r.coord_y);
    z = wrap_pos(r.coord_z);
    d = (dim_reg == 0) ? 1 : (dim_reg > 16) ? 16 : dim_reg;
    cx = bin_of(x, d);
    cy = bin_of(y, d);
    cz = bin_of(z, d);
    ovf = 1'b0;
    case (r.mode)
      clns_pkg::MODE_CLEAR: begin
        n_atoms = 0;
        n_sites = 0;
        foreach (head_ok[i]) head_ok[i] = 1'b0;
      end
      clns_pkg::MODE_LOAD: begin
        if (n_atoms < AtomCap) begin
          a = n_atoms;
          cell_no = cx * d * d + cy * d + cz;
          pos_x[a] = longint'(int'(x));
          pos_y[a] = longint'(int'(y));
          pos_z[a] = longint'(int'(z));
          link_ok[a] = 1'b0;
          if (cell_no >= 0 && cell_no < CellCap) begin
            link_atom[a] = head_atom[cell_no];
            link_ok[a] = head_ok[cell_no];
            head_atom[cell_no] = a;
            head_ok[cell_no] = 1'b1;
          end
          n_atoms = a + 1;
        end
      end
      clns_pkg::MODE_QUERY: begin
        site = n_sites & 10'h3FF;
        n_sites = (n_sites + 1) & 11'h7FF;
        if (d >= 3) begin
          for (int ox = -1; ox <= 1 && !ovf; ox++)
            for (int oy = -1; oy <= 1 && !ovf; oy++)
              for (int oz = -1; oz <= 1 && !ovf; oz++) begin
                cell_no = ((cx + ox + d) % d) * d * d + ((cy + oy + d) % d) * d
                          + ((cz + oz + d) % d);
                if (cell_no < 0 || cell_no >= CellCap) continue;
                a = head_atom[cell_no];
                v = head_ok[cell_no];
                steps = 0;
                while (v && a < AtomCap && steps < AtomCap) begin
                  if (a < n_atoms && is_near(x, y, z, a)) begin
                    if (hits.size() >= HitCap) begin
                      ovf = 1'b1;
                      break;
                    end
                    hits.push_back(a);
                  end
                  v = link_ok[a];
                  a = link_atom[a];
                  steps++;
                end
              end
        end else begin
          for (a = 0; a < n_atoms; a++) begin
            if (is_near(x, y, z, a)) begin
              if (hits.size() >= HitCap) begin
                ovf = 1'b1;
                break;
              end
              hits.push_back(a);
            end
          end
        end
        if (hits.size() == 0) begin
          res = '{atom_index: '0, site_number: site[9:0], found: 1'b0, last: 1'b1,
                  overflow: 1'b0};
          expected_hits.push_back(res);
        end
        foreach (hits[i]) begin
          res.atom_index = hits[i][9:0];
          res.site_number = site[9:0];
          res.found = 1'b1;
          res.last = (i == hits.size() - 1);
          res.overflow = res.last && ovf;
          expected_hits.push_back(res);
        end
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (push && !full) predict_search(in_req_i);
      if (!push || !full) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle) begin
          in_req_i <= pending_reqs.pop_front();
          push <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // long receiver stall
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= 400;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_res_o);
        end else begin
          if (out_res_o.atom_index !== expected_hits[0].atom_index ||
              out_res_o.site_number !== expected_hits[0].site_number ||
              out_res_o.found !== expected_hits[0].found ||
              out_res_o.last !== expected_hits[0].last ||
              out_res_o.overflow !== expected_hits[0].overflow) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", expected_hits[0], out_res_o);
          end
          void'(expected_hits.pop_front());
        end
      end
      if (hold_req || hold_left > 0) begin
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= rcv_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic write_reg(input logic [clns_pkg::CfgIdxW-1:0] idx, input int unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[clns_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      clns_pkg::REG_BOX: box_len = val & 32'h7FFF_FFFF;
      clns_pkg::REG_RADIUS: radius = val & 32'h3FFF_FFFF;
      clns_pkg::REG_DIM: dim_reg = val & 32'h1F;
      default: cell_len = val & 32'h7FFF_FFFF;
    endcase
  endtask

  task automatic set_search(input int unsigned b, r, d, c);
    write_reg(clns_pkg::REG_BOX, b);
    write_reg(clns_pkg::REG_RADIUS, r);
    write_reg(clns_pkg::REG_DIM, d);
    write_reg(clns_pkg::REG_CELL, c);
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || push || expected_hits.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic logic signed [31:0] pick_coord();
    longint bl;
    bl = (box_len == 0) ? 1 : box_len;
    if ($urandom_range(99) < 15) return $urandom;
    return 32'(longint'($urandom_range(0, 32'(bl + bl / 8))) - bl / 16);
  endfunction

  function automatic clns_pkg::in_req_t make_req(input logic [1:0] m);
    clns_pkg::in_req_t r;
    r.mode = m;
    r.coord_x = pick_coord();
    r.coord_y = pick_coord();
    r.coord_z = pick_coord();
    return r;
  endfunction

  function automatic clns_pkg::in_req_t rand_req();
    int p;
    p = $urandom_range(99);
    if (p < 2) return make_req(clns_pkg::MODE_CLEAR);
    if (p < 5) return make_req(2'd3);
    if (p < 35) return make_req(clns_pkg::MODE_QUERY);
    return make_req(clns_pkg::MODE_LOAD);
  endfunction

  function automatic clns_pkg::in_req_t fixed_req(input logic [1:0] m, input int x, y, z);
    clns_pkg::in_req_t r;
    r.mode = m;
    r.coord_x = x;
    r.coord_y = y;
    r.coord_z = z;
    return r;
  endfunction

  task automatic random_phase(input int count);
    @(negedge clk_i);
    repeat (count) pending_reqs.push_back(rand_req());
    drain();
  endtask

  initial begin
    int unsigned b, r, d;
    rst_ni <= 1'b0;
    foreach (head_ok[i]) head_ok[i] = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle = 29;
    rcv_idle = 77;
    set_search(655360, 65536, 5, 131072);
    @(negedge clk_i);
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 0, 0, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 0, 0, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 655359, 655359, 655359));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, -1, -1, -1));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, -2, -2, -2));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 655360, 655360, 655360));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'hFFFF_FFFF));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h5555_5555));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_LOAD, 70000, 65536, 60000));
    pending_reqs.push_back(fixed_req(2'd3, 32'hAAAA_AAAA, 32'h5555_5555, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 0, 0, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 655358, 1, 655358));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 327680, 327680, 327680));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, -1, -2, 655360));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_CLEAR, 0, 0, 0));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_QUERY, 65536, 65536, 65536));
    @(posedge clk_i);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    drain();
    random_phase(45);

    set_search(655360, 200000, 1, 655360);
    random_phase(45);

    snd_idle = 77;
    rcv_idle = 29;
    set_search(32'h7FFF_FFFF, 32'h3FFF_FFFF, 31, 0);
    random_phase(40);
    set_search(1, 1, 0, 1);
    random_phase(30);

    snd_idle = 0;
    rcv_idle = 0;
    b = $urandom_range(65536, 4000000);
    r = $urandom_range(b / 32, b / 6);
    d = b / (2 * r);
    set_search(b, r, d, b / d);
    random_phase(45);
    b = $urandom_range(2000000, 20000000);
    r = b / 32;
    set_search(b, r, 16, b / 16);
    random_phase(45);

    // dense box, then the same atoms scanned without cell lists, then queries after a clear
    set_search(655360, 131072, 3, 218453);
    @(negedge clk_i);
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_CLEAR, 0, 0, 0));
    repeat (6) pending_reqs.push_back(make_req(clns_pkg::MODE_LOAD));
    repeat (4) pending_reqs.push_back(make_req(clns_pkg::MODE_QUERY));
    drain();
    write_reg(clns_pkg::REG_DIM, 2);
    @(negedge clk_i);
    repeat (3) pending_reqs.push_back(make_req(clns_pkg::MODE_QUERY));
    pending_reqs.push_back(fixed_req(clns_pkg::MODE_CLEAR, 0, 0, 0));
    repeat (3) pending_reqs.push_back(make_req(clns_pkg::MODE_QUERY));
    drain();

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
